// File: rtl/hpv_pkg.sv
`timescale 1ns / 1ps

package hpv_pkg;

    // Limits of the naming rules
    localparam logic [6:0] LABEL_MAX      = 7'd63;
    localparam logic [7:0] NAME_MAX_BYTES = 8'd253;
    localparam logic [1:0] MIN_LABELS     = 2'd2;
    localparam logic [6:0] LOCAL_LEN      = 7'd5;

    // Characters of interest
    localparam logic [7:0] CH_WILDCARD = 8'h2A;
    localparam logic [7:0] CH_HYPHEN   = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;

    // Error codes, first one seen wins
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_BAD_CHAR      = 4'd1;
    localparam logic [3:0] ERR_EMPTY_LABEL   = 4'd2;
    localparam logic [3:0] ERR_LEAD_HYPHEN   = 4'd3;
    localparam logic [3:0] ERR_WILDCARDS     = 4'd4;
    localparam logic [3:0] ERR_TRAIL_HYPHEN  = 4'd5;
    localparam logic [3:0] ERR_LABEL_LONG    = 4'd6;
    localparam logic [3:0] ERR_FEW_LABELS    = 4'd7;
    localparam logic [3:0] ERR_FINAL_WILD    = 4'd8;
    localparam logic [3:0] ERR_NUMERIC_TLD   = 4'd9;
    localparam logic [3:0] ERR_LOCAL         = 4'd10;
    localparam logic [3:0] ERR_LENGTH        = 4'd11;

    // One input item
    typedef struct packed {
        logic [7:0] character;
        logic       end_of_name;
    } hpv_in_t;

    // One result item
    typedef struct packed {
        logic       valid_res;
        logic [3:0] error_code;
    } hpv_out_t;

    // Item leaving the input register for the checker
    typedef struct packed {
        logic    go;
        hpv_in_t item;
    } hpv_step_t;

    // Lower-case spelling of "local", by position
    function automatic logic [7:0] local_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h6C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/hostname_pattern_validator.sv
`timescale 1ns / 1ps

// Hostname / hostname-pattern validator.
// Input channel: one item per character (in_item.character), with
// in_item.end_of_name set on the closing item, whose character is ignored.
// in_valid/in_stall handshake; an item is taken when in_valid is high and
// in_stall is low. Output channel: one result item per end item,
// out_valid/out_stall handshake, carrying valid_res and error_code.
// cfg_we/cfg_data write pattern_mode; write it only while no name is in flight.
// Throughput: one item per cycle unless an end item waits in the input register
// for room in the result register; the check logic between the two is combinational.
// An accepted end item is held in the input register; its result is then
// registered in the result register, which drives out_valid.
// Reset clears all name tracking, sets plain-hostname mode and empties both
// registers. When the receiver stalls, the result is held; characters keep
// flowing, and the next end item waits in the input register, which then
// stalls the sender.

module hostname_pattern_validator
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  hpv_pkg::hpv_in_t in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output hpv_pkg::hpv_out_t out_item,
    input  logic             cfg_we,
    input  logic             cfg_data
);
    import hpv_pkg::*;

    logic      pattern_mode_reg;
    logic      out_free;
    hpv_step_t step;
    hpv_out_t  result;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            pattern_mode_reg <= cfg_data;
        end
    end

    hpv_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_free (out_free),
        .step     (step)
    );

    hpv_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pattern_mode (pattern_mode_reg),
        .step         (step),
        .result       (result)
    );

    hpv_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: rtl/hpv_in_stage.sv
`timescale 1ns / 1ps

module hpv_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hpv_pkg::hpv_in_t   in_item,
    input  logic               out_free,
    output hpv_pkg::hpv_step_t step
);
    import hpv_pkg::*;

    logic    full_reg;
    logic    full_next;
    hpv_in_t item_reg;
    logic    go;
    logic    accept;

    // A character always moves on; an end item waits for room in the result register
    assign go       = full_reg && (!item_reg.end_of_name || out_free);
    assign in_stall = full_reg && !go;
    assign accept   = in_valid && !in_stall;

    assign full_next = accept || (full_reg && !go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign step.go   = go;
    assign step.item = item_reg;

    // Stall only when an item is actually held
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> full_reg)
        else $error("input stall with empty register");

endmodule

// File: rtl/hpv_checker.sv
`timescale 1ns / 1ps

module hpv_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pattern_mode,
    input  hpv_pkg::hpv_step_t step,
    output hpv_pkg::hpv_out_t  result
);
    import hpv_pkg::*;

    // Per-name tracking state
    logic [3:0] first_error_reg,      first_error_next;
    logic       inside_label_reg,     inside_label_next;
    logic [6:0] label_length_reg,     label_length_next;
    logic [1:0] label_wildcards_reg,  label_wildcards_next;
    logic       prior_label_wild_reg, prior_label_wild_next;
    logic       label_all_digits_reg, label_all_digits_next;
    logic       last_was_hyphen_reg,  last_was_hyphen_next;
    logic       local_prefix_ok_reg,  local_prefix_ok_next;
    logic [1:0] label_count_reg,      label_count_next;
    logic [7:0] total_bytes_reg,      total_bytes_next;

    logic [7:0] ch;
    logic [7:0] ch_low;
    logic       is_digit;
    logic       is_alnum;
    logic       wild;
    logic       legal;
    logic       take;
    logic       finish;
    logic [1:0] count_closed;
    logic [3:0] code;

    assign ch       = step.item.character;
    assign ch_low   = ch | 8'h20;
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_alnum = is_digit || ((ch >= 8'h41) && (ch <= 8'h5A))
                    || ((ch >= 8'h61) && (ch <= 8'h7A));
    assign wild     = (ch == CH_WILDCARD) && pattern_mode;
    assign legal    = is_alnum || (ch == CH_HYPHEN) || (ch == CH_DOT) || wild;
    assign take     = step.go && !step.item.end_of_name && (first_error_reg == ERR_NONE);
    assign finish   = step.go && step.item.end_of_name;

    // Label count after closing the final label, saturating at 3
    assign count_closed = (label_count_reg == 2'd3) ? 2'd3 : label_count_reg + 2'd1;

    // Verdict on the end item
    always_comb
    begin
        if (first_error_reg != ERR_NONE)
            code = first_error_reg;
        else if (!inside_label_reg)
            code = ERR_EMPTY_LABEL;
        else if (last_was_hyphen_reg)
            code = ERR_TRAIL_HYPHEN;
        else if (label_length_reg > LABEL_MAX)
            code = ERR_LABEL_LONG;
        else if (count_closed < MIN_LABELS)
            code = ERR_FEW_LABELS;
        else if (pattern_mode && ((label_wildcards_reg != 2'd0) || prior_label_wild_reg))
            code = ERR_FINAL_WILD;
        else if (label_all_digits_reg)
            code = ERR_NUMERIC_TLD;
        else if ((label_length_reg == LOCAL_LEN) && local_prefix_ok_reg)
            code = ERR_LOCAL;
        else if (total_bytes_reg > NAME_MAX_BYTES)
            code = ERR_LENGTH;
        else
            code = ERR_NONE;
    end

    assign result.valid_res  = (code == ERR_NONE);
    assign result.error_code = code;

    // Per-character update; state after an error is don't-care until the end item
    always_comb
    begin
        first_error_next      = first_error_reg;
        inside_label_next     = inside_label_reg;
        label_length_next     = label_length_reg;
        label_wildcards_next  = label_wildcards_reg;
        prior_label_wild_next = prior_label_wild_reg;
        label_all_digits_next = label_all_digits_reg;
        last_was_hyphen_next  = last_was_hyphen_reg;
        local_prefix_ok_next  = local_prefix_ok_reg;
        label_count_next      = label_count_reg;
        total_bytes_next      = total_bytes_reg;

        if (finish)
        begin
            first_error_next      = ERR_NONE;
            inside_label_next     = 1'b0;
            label_length_next     = 7'd0;
            label_wildcards_next  = 2'd0;
            prior_label_wild_next = 1'b1;
            label_all_digits_next = 1'b1;
            last_was_hyphen_next  = 1'b0;
            local_prefix_ok_next  = 1'b1;
            label_count_next      = 2'd0;
            total_bytes_next      = 8'd0;
        end
        else if (take)
        begin
            if (!legal)
            begin
                first_error_next = ERR_BAD_CHAR;
            end
            else
            begin
                if (!wild && (total_bytes_reg != 8'hFF))
                    total_bytes_next = total_bytes_reg + 8'd1;

                if (!inside_label_reg && (ch == CH_DOT))
                begin
                    first_error_next = ERR_EMPTY_LABEL;
                end
                else if (!inside_label_reg && (ch == CH_HYPHEN))
                begin
                    first_error_next = ERR_LEAD_HYPHEN;
                end
                else if (ch != CH_DOT)
                begin
                    inside_label_next = 1'b1;
                    if (!is_digit)
                        label_all_digits_next = 1'b0;
                    if (wild)
                    begin
                        if (label_wildcards_reg >= 2'd2)
                            first_error_next = ERR_WILDCARDS;
                        else
                            label_wildcards_next = label_wildcards_reg + 2'd1;
                    end
                    else
                    begin
                        if ((label_length_reg >= LOCAL_LEN)
                            || (ch_low != local_char(label_length_reg[2:0])))
                            local_prefix_ok_next = 1'b0;
                        if (label_length_reg != 7'h7F)
                            label_length_next = label_length_reg + 7'd1;
                    end
                    last_was_hyphen_next = (ch == CH_HYPHEN);
                end
                else
                begin
                    // Dot closes the current label
                    if (last_was_hyphen_reg)
                    begin
                        first_error_next = ERR_TRAIL_HYPHEN;
                    end
                    else if (label_length_reg > LABEL_MAX)
                    begin
                        first_error_next = ERR_LABEL_LONG;
                    end
                    else
                    begin
                        label_count_next      = count_closed;
                        inside_label_next     = 1'b0;
                        label_all_digits_next = 1'b1;
                        prior_label_wild_next = (label_wildcards_reg != 2'd0);
                        label_wildcards_next  = 2'd0;
                        label_length_next     = 7'd0;
                        local_prefix_ok_next  = 1'b1;
                        last_was_hyphen_next  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_error_reg      <= ERR_NONE;
            inside_label_reg     <= 1'b0;
            label_length_reg     <= 7'd0;
            label_wildcards_reg  <= 2'd0;
            prior_label_wild_reg <= 1'b1;
            label_all_digits_reg <= 1'b1;
            last_was_hyphen_reg  <= 1'b0;
            local_prefix_ok_reg  <= 1'b1;
            label_count_reg      <= 2'd0;
            total_bytes_reg      <= 8'd0;
        end
        else
        begin
            first_error_reg      <= first_error_next;
            inside_label_reg     <= inside_label_next;
            label_length_reg     <= label_length_next;
            label_wildcards_reg  <= label_wildcards_next;
            prior_label_wild_reg <= prior_label_wild_next;
            label_all_digits_reg <= label_all_digits_next;
            last_was_hyphen_reg  <= last_was_hyphen_next;
            local_prefix_ok_reg  <= local_prefix_ok_next;
            label_count_reg      <= label_count_next;
            total_bytes_reg      <= total_bytes_next;
        end
    end

    // End item leaves a clean slate
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (first_error_reg == ERR_NONE) && (label_count_reg == 2'd0)
                   && (total_bytes_reg == 8'd0) && !inside_label_reg)
        else $error("state not cleared after end item");

    // First error is sticky until the end item
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((first_error_reg != ERR_NONE) && !finish)
            |=> (first_error_reg == $past(first_error_reg)))
        else $error("first error overwritten");

    // Verdict code stays within the defined set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (code <= ERR_LENGTH))
        else $error("undefined error code");

endmodule

// File: rtl/hpv_out_stage.sv
`timescale 1ns / 1ps

module hpv_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  hpv_pkg::hpv_step_t step,
    input  hpv_pkg::hpv_out_t  result,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_stall,
    output hpv_pkg::hpv_out_t  out_item
);
    import hpv_pkg::*;

    logic     full_reg;
    logic     full_next;
    hpv_out_t item_reg;
    logic     load;

    // Room when empty or when the held item leaves this cycle
    assign out_free  = !full_reg || !out_stall;
    assign load      = step.go && step.item.end_of_name;
    assign full_next = load || (full_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = full_reg;
    assign out_item  = item_reg;

    // Verdict bit agrees with the code
    a_verdict_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.valid_res == (out_item.error_code == ERR_NONE)))
        else $error("verdict and error code disagree");

    // Never load over a held, stalled item
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && out_stall) |-> !load)
        else $error("result overwritten while stalled");

endmodule
